[hdl/mfap_pkg.sv]
// ----------------------------------------------------------------------------
// mfap_pkg: shared types and constants
// Widths, action codes, sequencer states and the result record of the
// max-flow unit.
// ----------------------------------------------------------------------------
package mfap_pkg;

    localparam int NODE_BITS  = 6;
    localparam int MAX_NODES  = 1 << NODE_BITS;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int CAP_BITS   = 24;
    localparam int FLOW_BITS  = CAP_BITS + 1;   // signed edge flow
    localparam int RES_BITS   = CAP_BITS + 2;   // signed residual
    localparam int NECK_BITS  = CAP_BITS + 1;   // positive residual
    localparam int TOTAL_BITS = 31;
    localparam int CNT_BITS   = NODE_BITS + 1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_CLR_CAP,
        ST_IDLE,
        ST_CLR_FLOW,
        ST_SEARCH_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_TR_P,
        ST_TR_PW,
        ST_TR_EV,
        ST_AUG_P,
        ST_AUG_PW,
        ST_AUG_F,
        ST_AUG_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] max_flow;
        logic                  same_endpoints;
    } result_t;

endpackage

[hdl/mfap_req_if.sv]
// ----------------------------------------------------------------------------
// mfap_req_if: request channel
// Valid/ready channel carrying one load, run or clear request.
// ----------------------------------------------------------------------------
interface mfap_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [mfap_pkg::NODE_BITS-1:0] from_node;
    logic [mfap_pkg::NODE_BITS-1:0] to_node;
    logic [mfap_pkg::CAP_BITS-1:0]  edge_capacity;
    logic [mfap_pkg::NODE_BITS-1:0] source_node;
    logic [mfap_pkg::NODE_BITS-1:0] sink_node;

    modport source (output valid, action, from_node, to_node, edge_capacity,
                    source_node, sink_node, input ready);
    modport sink   (input valid, action, from_node, to_node, edge_capacity,
                    source_node, sink_node, output ready);
endinterface

[hdl/mfap_res_if.sv]
// ----------------------------------------------------------------------------
// mfap_res_if: result channel
// Valid/ready channel carrying one max-flow result.
// ----------------------------------------------------------------------------
interface mfap_res_if;
    logic                            valid;
    logic                            ready;
    logic [mfap_pkg::TOTAL_BITS-1:0] max_flow;
    logic                            same_endpoints;

    modport source (output valid, max_flow, same_endpoints, input ready);
    modport sink   (input valid, max_flow, same_endpoints, output ready);
endinterface

[hdl/mfap_core.sv]
// ----------------------------------------------------------------------------
// mfap_core: Edmonds-Karp sequencer
// Holds capacity, flow, parent and queue memories and walks them with one
// shared residual subtract/compare unit.
// ----------------------------------------------------------------------------
module mfap_core (
    input  logic              clk,
    input  logic              rst_n,
    mfap_req_if.sink          req,
    output logic              done_valid,
    input  logic              done_ready,
    output mfap_pkg::result_t done_data
);

    localparam int NB = mfap_pkg::NODE_BITS;
    localparam int AB = mfap_pkg::ADDR_BITS;
    localparam int CB = mfap_pkg::CAP_BITS;
    localparam int FB = mfap_pkg::FLOW_BITS;
    localparam int RB = mfap_pkg::RES_BITS;
    localparam int KB = mfap_pkg::NECK_BITS;
    localparam int TB = mfap_pkg::TOTAL_BITS;
    localparam int QB = mfap_pkg::CNT_BITS;
    localparam int MN = mfap_pkg::MAX_NODES;

    // memories
    logic [CB-1:0] cap_mem  [2**AB];
    logic [FB-1:0] flow_mem [2**AB];
    logic [NB-1:0] par_mem  [MN];
    logic [NB-1:0] q_mem    [MN];

    mfap_pkg::state_t state_reg, state_next;
    logic [AB-1:0] cnt_reg, cnt_next;
    logic [NB-1:0] u_reg, u_next;
    logic [NB-1:0] v_reg, v_next;
    logic [NB-1:0] src_reg, src_next;
    logic [NB-1:0] snk_reg, snk_next;
    logic [QB-1:0] head_reg, head_next;
    logic [QB-1:0] tail_reg, tail_next;
    logic [MN-1:0] visited_reg, visited_next;
    logic [KB-1:0] neck_reg, neck_next;
    logic          neck_ok_reg, neck_ok_next;
    logic [TB-1:0] total_reg, total_next;
    logic          same_reg, same_next;

    logic [CB-1:0] cap_rd;
    logic [FB-1:0] flow_rd;
    logic [NB-1:0] par_rd;
    logic [NB-1:0] q_rd;

    logic          cap_we;
    logic [AB-1:0] cap_waddr;
    logic [CB-1:0] cap_wd;
    logic          flow_we;
    logic [AB-1:0] flow_waddr;
    logic [FB-1:0] flow_wd;
    logic [AB-1:0] rd_addr;
    logic          par_we;
    logic          q_we;

    logic signed [RB-1:0] resid;
    logic                 resid_pos;
    logic [TB:0]          sum;

    // shared residual unit
    assign resid     = $signed({2'b00, cap_rd}) - $signed({flow_rd[FB-1], flow_rd});
    assign resid_pos = !resid[RB-1] && (resid != '0);
    assign sum       = {1'b0, total_reg} + {{(TB+1-KB){1'b0}}, neck_reg};

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[cap_waddr] <= cap_wd;
        end
        cap_rd <= cap_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_waddr] <= flow_wd;
        end
        flow_rd <= flow_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[v_reg] <= u_reg;
        end
        par_rd <= par_mem[v_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[NB-1:0]] <= v_reg;
        end
        q_rd <= q_mem[head_reg[NB-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mfap_pkg::ST_CLR_CAP;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            neck_ok_reg <= 1'b0;
            total_reg   <= '0;
            same_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            visited_reg <= visited_next;
            neck_ok_reg <= neck_ok_next;
            total_reg   <= total_next;
            same_reg    <= same_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        src_reg  <= src_next;
        snk_reg  <= snk_next;
        neck_reg <= neck_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        visited_next = visited_reg;
        neck_next    = neck_reg;
        neck_ok_next = neck_ok_reg;
        total_next   = total_reg;
        same_next    = same_reg;
        cap_we       = 1'b0;
        cap_waddr    = cnt_reg;
        cap_wd       = '0;
        flow_we      = 1'b0;
        flow_waddr   = cnt_reg;
        flow_wd      = '0;
        rd_addr      = {u_reg, v_reg};
        par_we       = 1'b0;
        q_we         = 1'b0;
        req.ready    = 1'b0;
        done_valid   = 1'b0;

        unique case (state_reg)
            mfap_pkg::ST_CLR_CAP:
            begin
                cap_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = mfap_pkg::ST_IDLE;
                end
            end
            mfap_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                src_next  = req.source_node;
                snk_next  = req.sink_node;
                if (req.valid)
                begin
                    unique case (mfap_pkg::action_t'(req.action))
                        mfap_pkg::ACT_LOAD:
                        begin
                            cap_we    = 1'b1;
                            cap_waddr = {req.from_node, req.to_node};
                            cap_wd    = req.edge_capacity;
                        end
                        mfap_pkg::ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = mfap_pkg::ST_CLR_CAP;
                        end
                        mfap_pkg::ACT_RUN:
                        begin
                            total_next = '0;
                            cnt_next   = '0;
                            if (req.source_node == req.sink_node)
                            begin
                                same_next  = 1'b1;
                                state_next = mfap_pkg::ST_DONE;
                            end
                            else
                            begin
                                same_next  = 1'b0;
                                state_next = mfap_pkg::ST_CLR_FLOW;
                            end
                        end
                        mfap_pkg::ACT_NONE:
                        begin
                        end
                    endcase
                end
            end
            mfap_pkg::ST_CLR_FLOW:
            begin
                flow_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = mfap_pkg::ST_SEARCH_INIT;
                end
            end
            mfap_pkg::ST_SEARCH_INIT:
            begin
                visited_next          = '0;
                visited_next[src_reg] = 1'b1;
                v_next                = src_reg;   // queue slot 0 takes the source
                q_we                  = 1'b0;
                head_next             = '0;
                tail_next             = '0;
                state_next            = mfap_pkg::ST_POP;
                // push source by reusing the scan push path next cycle
                u_next                = src_reg;
                state_next            = mfap_pkg::ST_SCAN_EV;
                neck_ok_next          = 1'b0;
            end
            mfap_pkg::ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = mfap_pkg::ST_DONE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = mfap_pkg::ST_POP_WAIT;
                end
            end
            mfap_pkg::ST_POP_WAIT:
            begin
                u_next     = q_rd;
                v_next     = '0;
                state_next = mfap_pkg::ST_SCAN_RD;
            end
            mfap_pkg::ST_SCAN_RD:
            begin
                state_next = mfap_pkg::ST_SCAN_EV;
            end
            mfap_pkg::ST_SCAN_EV:
            begin
                if (!neck_ok_reg)
                begin
                    // first pass after search init: enqueue the source
                    q_we         = 1'b1;
                    tail_next    = tail_reg + 1'b1;
                    neck_ok_next = 1'b1;
                    state_next   = mfap_pkg::ST_POP;
                end
                else
                begin
                    if (!visited_reg[v_reg] && resid_pos)
                    begin
                        visited_next[v_reg] = 1'b1;
                        par_we              = 1'b1;
                        if (v_reg == snk_reg)
                        begin
                            state_next = mfap_pkg::ST_TR_P;
                        end
                        else if (!tail_reg[QB-1])
                        begin
                            q_we      = 1'b1;
                            tail_next = tail_reg + 1'b1;
                        end
                    end
                    if (!(!visited_reg[v_reg] && resid_pos && v_reg == snk_reg))
                    begin
                        v_next     = v_reg + 1'b1;
                        state_next = (&v_reg) ? mfap_pkg::ST_POP : mfap_pkg::ST_SCAN_RD;
                    end
                    else
                    begin
                        neck_ok_next = 1'b0;
                    end
                end
            end
            mfap_pkg::ST_TR_P:
            begin
                state_next = mfap_pkg::ST_TR_PW;
            end
            mfap_pkg::ST_TR_PW:
            begin
                rd_addr    = {par_rd, v_reg};
                u_next     = par_rd;
                state_next = mfap_pkg::ST_TR_EV;
            end
            mfap_pkg::ST_TR_EV:
            begin
                if (!neck_ok_reg || (resid[KB-1:0] < neck_reg))
                begin
                    neck_next = resid[KB-1:0];
                end
                neck_ok_next = 1'b1;
                v_next       = u_reg;
                if (u_reg == src_reg)
                begin
                    v_next     = snk_reg;
                    state_next = mfap_pkg::ST_AUG_P;
                end
                else
                begin
                    state_next = mfap_pkg::ST_TR_P;
                end
            end
            mfap_pkg::ST_AUG_P:
            begin
                state_next = mfap_pkg::ST_AUG_PW;
            end
            mfap_pkg::ST_AUG_PW:
            begin
                rd_addr    = {par_rd, v_reg};
                u_next     = par_rd;
                state_next = mfap_pkg::ST_AUG_F;
            end
            mfap_pkg::ST_AUG_F:
            begin
                flow_we    = 1'b1;
                flow_waddr = {u_reg, v_reg};
                flow_wd    = flow_rd + neck_reg;
                rd_addr    = {v_reg, u_reg};
                state_next = mfap_pkg::ST_AUG_R;
            end
            mfap_pkg::ST_AUG_R:
            begin
                flow_we    = 1'b1;
                flow_waddr = {v_reg, u_reg};
                flow_wd    = flow_rd - neck_reg;
                v_next     = u_reg;
                if (u_reg == src_reg)
                begin
                    total_next = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
                    state_next = mfap_pkg::ST_SEARCH_INIT;
                end
                else
                begin
                    state_next = mfap_pkg::ST_AUG_P;
                end
            end
            mfap_pkg::ST_DONE:
            begin
                done_valid = 1'b1;
                if (done_ready)
                begin
                    state_next = mfap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfap_pkg::ST_IDLE;
            end
        endcase
    end

    assign done_data.max_flow       = total_reg;
    assign done_data.same_endpoints = same_reg;

endmodule

[hdl/max_flow_augmenting_paths_unit.sv]
// ----------------------------------------------------------------------------
// max_flow_augmenting_paths_unit: Edmonds-Karp max-flow engine
// Capacity matrix loads, matrix clears and max-flow runs over a 64-node
// graph, with a registered result stage.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+-----------------------------------------------------------
//  req     | in  | action, from_node, to_node, edge_capacity, source_node,
//          |     | sink_node
//  res     | out | max_flow, same_endpoints (one per run request)
//
//  Load and no-op requests are handled in the idle state. A clear request
//  sweeps the capacity memory; the same sweep runs after reset, during
//  which req.ready stays low. A run first sweeps the flow memory, then
//  each search reads one edge at a time and each path is traced and then
//  augmented hop by hop; the shared read address of the capacity/flow
//  memories sets that pace. Source equal to sink skips the sweep and the
//  search. A stalled result sits in the output register; the next run
//  waits only if it finishes first.
// ----------------------------------------------------------------------------
module max_flow_augmenting_paths_unit (
    input  logic clk,
    input  logic rst_n,
    mfap_req_if.sink   req,
    mfap_res_if.source res
);

    logic              done_valid;
    logic              done_ready;
    mfap_pkg::result_t done_data;

    logic                            out_valid_reg;
    logic [mfap_pkg::TOTAL_BITS-1:0] out_flow_reg;
    logic                            out_same_reg;

    mfap_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_data  (done_data)
    );

    // output register frees the core as soon as the slot is empty or drained
    assign done_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            out_flow_reg <= done_data.max_flow;
            out_same_reg <= done_data.same_endpoints;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.max_flow       = out_flow_reg;
    assign res.same_endpoints = out_same_reg;

endmodule
